// File: src/ipd_pkg.sv
// Shared constants, types and the helper function of the isolated pixel detector.
package ipd_pkg;

   // Largest side length that the row delay lines can hold.
   localparam int MAX_SIZE = 32;
   // Width of the image size register.
   localparam int SIZE_W   = 6;
   // Width of the row and column fields of a result.
   localparam int POS_W    = 5;
   // Row counter width: it also counts the virtual row below the image.
   localparam int CNT_W    = $clog2(MAX_SIZE + 1);
   // Column counter width and delay line cell index width.
   localparam int TAP_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

   typedef enum logic [2:0] {
      ST_PIXEL = 3'b001,
      ST_EDGE  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   // What the sequencer does in the current cycle.
   typedef struct packed {
      logic             shift_lines;
      logic             shift_win;
      logic             feed_pixel;
      logic             emit;
      logic             last;
      logic             mask_top;
      logic             mask_left;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } step_type;

   // Out-of-range sizes: zero acts as one, anything above the maximum as the maximum.
   function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] value);
      logic [CNT_W-1:0] result;
      if (value == SIZE_W'(0)) begin
         result = CNT_W'(1);
      end else if (value > SIZE_W'(MAX_SIZE)) begin
         result = CNT_W'(MAX_SIZE);
      end else begin
         result = CNT_W'(value);
      end
      return result;
   endfunction

endpackage

// File: src/isolated_pixel_detector.sv
// Top level of the isolated pixel detector: size register, delay lines and result register.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_pixel
//   rsp      out        rsp_valid / rsp_stall     rsp_row, rsp_col, rsp_isolated, rsp_last
//   csr      in         csr_we                    csr_image_size
//
// Pixels are taken at one per cycle while the sequencer is in ST_PIXEL and not held. After
// the last pixel of every row from the second row on, an ST_EDGE step decides the right-hand
// column, and after the final pixel of the image ST_FLUSH pushes a blank row of N pixels (N
// being the side length) through the two delay lines, closed by an ST_EDGE step, to decide
// the last row. The sequencer makes these extra steps and steps the single window once per
// cycle unless held; any cycle waits while the result register holds a stalled result.
// Reset is synchronous and clears the sequencer, the result valid flag and sets the size
// to the maximum; the delay line cells are not cleared, as rows outside the image are masked.
// A stall on the result side blocks the sequencer and so backs up into req_stall.
module isolated_pixel_detector (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ipd_pkg::POS_W-1:0]  rsp_row,
   output logic [ipd_pkg::POS_W-1:0]  rsp_col,
   output logic                       rsp_isolated,
   output logic                       rsp_last,
   input  logic                       csr_we,
   input  logic [ipd_pkg::SIZE_W-1:0] csr_image_size
);

   logic [ipd_pkg::SIZE_W-1:0]   image_size_ff;
   logic [ipd_pkg::CNT_W-1:0]    size;
   logic [ipd_pkg::TAP_W-1:0]    entry_sel;
   logic                         out_free;
   ipd_pkg::step_type            step;

   logic                         line1_in;
   logic [ipd_pkg::MAX_SIZE-1:0] line1_q;
   logic [ipd_pkg::MAX_SIZE-1:0] line2_q;
   logic [2:0]                   col_in;
   logic                         isolated;

   logic                         rsp_valid_ff;
   logic [ipd_pkg::POS_W-1:0]    rsp_row_ff;
   logic [ipd_pkg::POS_W-1:0]    rsp_col_ff;
   logic                         rsp_isolated_ff;
   logic                         rsp_last_ff;

   // Size register; the sequencer sees the clamped side length.
   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= ipd_pkg::SIZE_W'(ipd_pkg::MAX_SIZE);
      end else if (csr_we) begin
         image_size_ff <= csr_image_size;
      end
   end

   assign size = ipd_pkg::clamp_size(image_size_ff);

   // The result register is free when empty or when its result leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   ipd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .csr_we    (csr_we),
      .size      (size),
      .req_stall (req_stall),
      .step      (step)
   );

   // Each delay line is a chain of cells. Data enters at the cell that leaves exactly N
   // cells to the end, so the line delays by one image row whatever the size.
   assign entry_sel = ipd_pkg::TAP_W'(ipd_pkg::CNT_W'(ipd_pkg::MAX_SIZE) - size);
   assign line1_in  = step.feed_pixel & req_pixel;

   for (genvar i = 0; i < ipd_pkg::MAX_SIZE; i++) begin : g_cells
      logic load_here;
      assign load_here = entry_sel == ipd_pkg::TAP_W'(i);

      ipd_cell u_cell1 (
         .clock     (clock),
         .shift     (step.shift_lines),
         .load_here (load_here),
         .prev_in   ((i == 0) ? line1_in : line1_q[(i == 0) ? 0 : i - 1]),
         .line_in   (line1_in),
         .q         (line1_q[i])
      );

      ipd_cell u_cell2 (
         .clock     (clock),
         .shift     (step.shift_lines),
         .load_here (load_here),
         .prev_in   ((i == 0) ? line1_q[ipd_pkg::MAX_SIZE-1] : line2_q[(i == 0) ? 0 : i - 1]),
         .line_in   (line1_q[ipd_pkg::MAX_SIZE-1]),
         .q         (line2_q[i])
      );
   end

   // New window column: two rows up, one row up and the incoming pixel. The extra step at
   // the end of a row shifts in a blank column, which stands for the right-hand border.
   assign col_in = step.shift_lines ?
                   {line1_in, line1_q[ipd_pkg::MAX_SIZE-1], line2_q[ipd_pkg::MAX_SIZE-1]} :
                   3'b000;

   ipd_window u_window (
      .clock    (clock),
      .step     (step),
      .col_in   (col_in),
      .isolated (isolated)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.emit) begin
         rsp_row_ff      <= step.row;
         rsp_col_ff      <= step.col;
         rsp_isolated_ff <= isolated;
         rsp_last_ff     <= step.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row      = rsp_row_ff;
   assign rsp_col      = rsp_col_ff;
   assign rsp_isolated = rsp_isolated_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: src/ipd_cell.sv
// One bit cell of a row delay line.
module ipd_cell (
   input  logic clock,
   input  logic shift,
   input  logic load_here,
   input  logic prev_in,
   input  logic line_in,
   output logic q
);

   logic q_ff;
   logic q_in;

   // The entry cell takes the line input, every other cell its left neighbour.
   assign q_in = load_here ? line_in : prev_in;

   always_ff @(posedge clock) begin
      if (shift) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: src/ipd_window.sv
// Three by three pixel window and the isolation decision on its centre.
module ipd_window (
   input  logic               clock,
   input  ipd_pkg::step_type  step,
   input  logic [2:0]         col_in,
   output logic               isolated
);

   // win_ff[k] is column k, 0 the oldest; bit 0 top row, bit 2 bottom row.
   logic [2:0][2:0] win_ff;
   logic [2:0][2:0] win_in;
   logic [2:0][2:0] masked;
   logic            centre;

   assign win_in[0] = win_ff[1];
   assign win_in[1] = win_ff[2];
   assign win_in[2] = col_in;

   always_ff @(posedge clock) begin
      if (step.shift_win) begin
         win_ff <= win_in;
      end
   end

   // Pixels above the first row or left of the first column lie outside the image.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         masked[k]    = win_in[k];
         masked[k][0] = win_in[k][0] & ~step.mask_top;
         if (k == 0) begin
            masked[k] = masked[k] & {3{~step.mask_left}};
         end
      end
      centre       = masked[1][1];
      masked[1][1] = 1'b0;
   end

   assign isolated = centre & ~(|masked);

endmodule

// File: src/ipd_ctrl.sv
// Sequencer: raster position counters and the per-cycle step of the detector.
module ipd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      out_free,
   input  logic                      csr_we,
   input  logic [ipd_pkg::CNT_W-1:0] size,
   output logic                      req_stall,
   output ipd_pkg::step_type         step
);

   ipd_pkg::state_type        state_ff, state_in;
   logic [ipd_pkg::CNT_W-1:0] row_ff, row_in;
   logic [ipd_pkg::TAP_W-1:0] col_ff, col_in;

   logic                      go;
   logic                      col_end;
   logic                      row_zero;
   logic                      row_last;
   logic                      row_past;
   logic [ipd_pkg::CNT_W-1:0] row_m1;
   logic [ipd_pkg::TAP_W-1:0] col_m1;
   logic [ipd_pkg::CNT_W-1:0] size_m1;

   assign size_m1  = size - ipd_pkg::CNT_W'(1);
   assign row_m1   = row_ff - ipd_pkg::CNT_W'(1);
   assign col_m1   = col_ff - ipd_pkg::TAP_W'(1);
   assign col_end  = ipd_pkg::CNT_W'(col_ff) == size_m1;
   assign row_zero = row_ff == ipd_pkg::CNT_W'(0);
   assign row_last = row_ff == size_m1;
   assign row_past = row_ff == size;

   assign req_stall = !((state_ff == ipd_pkg::ST_PIXEL) && out_free);

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      go             = out_free;
      step           = '0;
      step.row       = row_m1[ipd_pkg::POS_W-1:0];
      step.col       = ipd_pkg::POS_W'(col_m1);
      step.mask_top  = row_ff == ipd_pkg::CNT_W'(1);
      step.mask_left = col_ff == ipd_pkg::TAP_W'(1);
      unique case (state_ff)
         ipd_pkg::ST_PIXEL: begin
            go               = out_free && req_valid;
            step.shift_lines = go;
            step.shift_win   = go;
            step.feed_pixel  = 1'b1;
            step.emit        = go && !row_zero && (col_ff != ipd_pkg::TAP_W'(0));
            if (go) begin
               if (!col_end) begin
                  col_in = col_ff + ipd_pkg::TAP_W'(1);
               end else if (!row_zero) begin
                  state_in = ipd_pkg::ST_EDGE;
               end else begin
                  row_in   = row_ff + ipd_pkg::CNT_W'(1);
                  col_in   = '0;
                  state_in = row_last ? ipd_pkg::ST_FLUSH : ipd_pkg::ST_PIXEL;
               end
            end
         end
         ipd_pkg::ST_EDGE: begin
            step.shift_win = go;
            step.emit      = go;
            step.last      = row_past;
            step.col       = ipd_pkg::POS_W'(col_ff);
            step.mask_left = col_ff == ipd_pkg::TAP_W'(0);
            if (go) begin
               col_in   = '0;
               row_in   = row_past ? ipd_pkg::CNT_W'(0) : row_ff + ipd_pkg::CNT_W'(1);
               state_in = (!row_past && row_last) ? ipd_pkg::ST_FLUSH : ipd_pkg::ST_PIXEL;
            end
         end
         ipd_pkg::ST_FLUSH: begin
            step.shift_lines = go;
            step.shift_win   = go;
            step.emit        = go && (col_ff != ipd_pkg::TAP_W'(0));
            if (go) begin
               if (col_end) begin
                  state_in = ipd_pkg::ST_EDGE;
               end else begin
                  col_in = col_ff + ipd_pkg::TAP_W'(1);
               end
            end
         end
         default: begin
            state_in = ipd_pkg::ST_PIXEL;
            row_in   = '0;
            col_in   = '0;
         end
      endcase
      // A size write restarts the image.
      if (csr_we) begin
         state_in = ipd_pkg::ST_PIXEL;
         row_in   = '0;
         col_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipd_pkg::ST_PIXEL;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

// File: src/ipd_checker.sv
// Port-level checks of the isolated pixel detector and their binding to it.
module ipd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [ipd_pkg::POS_W-1:0]  rsp_row,
   input logic [ipd_pkg::POS_W-1:0]  rsp_col,
   input logic                       rsp_isolated,
   input logic                       rsp_last
);

   // A stalled result stays in place unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col)
                                 && $stable(rsp_isolated) && $stable(rsp_last))
      else $error("stalled result changed");

   // The final pixel of a square image lies on the diagonal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_row == rsp_col)
      else $error("last result off the diagonal");

   // No pixel is taken while a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pixel taken while result is stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind isolated_pixel_detector ipd_checker u_ipd_checker (.*);

// File: verif/tb_isolated_pixel_detector.sv
// Self-checking testbench of the isolated pixel detector, with its own predictor and scoreboard.
module tb_isolated_pixel_detector;

   // One decision as it leaves the block on the result channel.
   typedef struct packed {
      logic [ipd_pkg::POS_W-1:0] row;
      logic [ipd_pkg::POS_W-1:0] col;
      logic                      isolated;
      logic                      last;
   } decision_type;

   // Predictor and scoreboard in one. It keeps its own copy of the size register, the
   // position counters and the three most recent rows. Every pixel transfer on the input
   // side queues the decisions that pixel completes. Every result transfer is then checked
   // against the oldest queued decision.
   class scoreboard_type;
      bit           line_store [3][ipd_pkg::MAX_SIZE];
      int unsigned  side_reg;
      int unsigned  row_cnt;
      int unsigned  col_cnt;
      decision_type pending_decisions [$];
      int unsigned  mismatch_count;

      function new();
         foreach (line_store[i, j]) line_store[i][j] = 1'b0;
         side_reg       = ipd_pkg::MAX_SIZE;
         row_cnt        = 0;
         col_cnt        = 0;
         mismatch_count = 0;
      endfunction

      // A write to the size register also starts a fresh image.
      function void write_size(logic [ipd_pkg::SIZE_W-1:0] value);
         side_reg = value;
         row_cnt  = 0;
         col_cnt  = 0;
      endfunction

      // A size of zero behaves as one, and anything beyond the maximum as the maximum.
      function int unsigned active_side();
         int unsigned n;
         n = side_reg;
         if (n == 0) n = 1;
         if (n > ipd_pkg::MAX_SIZE) n = ipd_pkg::MAX_SIZE;
         return n;
      endfunction

      // Pixels outside the image, or in rows not yet received, read as clear.
      function bit pixel_at(int r, int c, int cur_row, int n);
         if (r < 0 || r > cur_row || r >= n || c < 0 || c >= n) return 1'b0;
         return line_store[r % 3][c];
      endfunction

      function void queue_decision(int r, int c, int cur_row, int n, bit is_last);
         decision_type d;
         bit           neighbours;
         neighbours = 1'b0;
         for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
               if (dr != 0 || dc != 0)
                  neighbours |= pixel_at(r + dr, c + dc, cur_row, n);
         d.row      = ipd_pkg::POS_W'(r);
         d.col      = ipd_pkg::POS_W'(c);
         d.isolated = pixel_at(r, c, cur_row, n) & ~neighbours;
         d.last     = is_last;
         pending_decisions.push_back(d);
      endfunction

      function void take_pixel(logic value);
         int n;
         int r;
         int c;
         n = active_side();
         if (row_cnt >= n || col_cnt >= n) begin
            row_cnt = 0;
            col_cnt = 0;
         end
         r = row_cnt;
         c = col_cnt;
         line_store[r % 3][c] = value;
         // The decision one row up and one column left is now complete.
         if (r >= 1 && c >= 1) queue_decision(r - 1, c - 1, r, n, 1'b0);
         // At the end of a row the right-hand pixel of the row above follows too.
         if (r >= 1 && c == n - 1) queue_decision(r - 1, n - 1, r, n, 1'b0);
         // The final pixel of the image flushes the whole bottom row.
         if (r == n - 1 && c == n - 1)
            for (int cc = 0; cc < n; cc++) queue_decision(r, cc, r, n, cc == n - 1);
         col_cnt++;
         if (col_cnt >= n) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= n) row_cnt = 0;
         end
      endfunction

      function void check_decision(decision_type got);
         decision_type want;
         if (pending_decisions.size() == 0) begin
            $display("%0t: result with none expected: row %0d col %0d isolated %0b last %0b",
                     $time, got.row, got.col, got.isolated, got.last);
            mismatch_count++;
            return;
         end
         want = pending_decisions.pop_front();
         if (got.row !== want.row || got.col !== want.col ||
             got.isolated !== want.isolated || got.last !== want.last) begin
            $display("%0t: decision mismatch: expected row %0d col %0d isolated %0b last %0b,",
                     $time, want.row, want.col, want.isolated, want.last);
            $display("%0t:   actual row %0d col %0d isolated %0b last %0b",
                     $time, got.row, got.col, got.isolated, got.last);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_pixel;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [ipd_pkg::POS_W-1:0]  rsp_row;
   logic [ipd_pkg::POS_W-1:0]  rsp_col;
   logic                       rsp_isolated;
   logic                       rsp_last;
   logic                       csr_we;
   logic [ipd_pkg::SIZE_W-1:0] csr_image_size;

   // Idling on each side can be switched off; the closing phase runs with both off.
   bit                         gaps_on;
   bit                         stalls_on;

   scoreboard_type predictor = new();

   isolated_pixel_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row        (rsp_row),
      .rsp_col        (rsp_col),
      .rsp_isolated   (rsp_isolated),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_image_size (csr_image_size)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A generous ceiling on the whole run. A correct run needs well under a tenth of it,
   // even with every pixel and every result held up by the longest idle bursts.
   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // All observation happens at the rising edge, where the block samples too. Inputs only
   // move at the falling edge, so the values seen here are the ones the block acts upon.
   // A pixel transfer is noted before a result transfer of the same edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) predictor.write_size(csr_image_size);
         if (req_valid && !req_stall) predictor.take_pixel(req_pixel);
         if (rsp_valid && !rsp_stall)
            predictor.check_decision(decision_type'{rsp_row, rsp_col, rsp_isolated, rsp_last});
      end
   end

   // The result side holds off in bursts, independent of rsp_valid.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one pixel, possibly after an idle burst, and returns at the edge of its transfer.
   // req_valid stays high into the next call, so back-to-back pixels run at full rate.
   task automatic send_pixel(input logic value);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Pixels set with a probability of density sixteenths.
   task automatic send_random(input int count, input int density);
      for (int i = 0; i < count; i++) send_pixel($urandom_range(0, 15) < density);
   endtask

   // The lowest bit goes first, matching raster order.
   task automatic send_pattern(input logic [31:0] bits, input int count);
      for (int i = 0; i < count; i++) send_pixel(bits[i]);
   endtask

   // Waits until every predicted decision has been transferred. Pixels of a top row give
   // no result, so a further pause lets the block settle completely before the size
   // register may be touched.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predictor.pending_decisions.size() != 0) @(posedge clock);
      repeat (ipd_pkg::MAX_SIZE + 8) @(posedge clock);
   endtask

   task automatic write_size(input logic [ipd_pkg::SIZE_W-1:0] value);
      @(negedge clock);
      csr_we         <= 1'b1;
      csr_image_size <= value;
      @(negedge clock);
      csr_we         <= 1'b0;
   endtask

   initial begin
      int random_items;
      int size_value;
      int side;
      int count;
      int repeats;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_pixel      = 1'b0;
      csr_we         = 1'b0;
      csr_image_size = '0;
      gaps_on        = 1'b1;
      stalls_on      = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The size after reset is the maximum: two full rows only yield decisions with the
      // right positions if it is, and the end of the second row reaches the right-hand
      // column. The image is then cut short by the next write, which has to restart it.
      send_random(2 * ipd_pkg::MAX_SIZE, 4);
      wait_idle();

      // Size zero behaves as one: every pixel is a whole image and its own last decision.
      write_size(ipd_pkg::SIZE_W'(0));
      send_pattern(32'b01, 2);
      wait_idle();
      write_size(ipd_pkg::SIZE_W'(1));
      send_pattern(32'b1, 1);
      wait_idle();

      // Two by two: a lone corner pixel, then two diagonal neighbours that spoil each other.
      write_size(ipd_pkg::SIZE_W'(2));
      send_pattern(32'b0001, 4);
      send_pattern(32'b1001, 4);
      wait_idle();

      // Three by three: a lone centre pixel, then a fully set image.
      write_size(ipd_pkg::SIZE_W'(3));
      send_pattern(32'b000010000, 9);
      send_pattern(32'b111111111, 9);
      wait_idle();

      // Random part: mostly whole small images of varying density, some cut short, and the
      // occasional out-of-range size with at most three rows of pixels before the next restart.
      random_items = 0;
      while (random_items < 170) begin
         unique case ($urandom_range(0, 7))
            0:       size_value = $urandom_range(0, 1);
            1, 2, 3: size_value = $urandom_range(2, 4);
            4, 5:    size_value = $urandom_range(5, 8);
            6:       size_value = $urandom_range(9, 10);
            default: size_value = $urandom_range(ipd_pkg::MAX_SIZE + 1, 63);
         endcase
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         write_size(ipd_pkg::SIZE_W'(size_value));
         if (size_value > ipd_pkg::MAX_SIZE) begin
            count = $urandom_range(1, 3 * ipd_pkg::MAX_SIZE);
            send_random(count, $urandom_range(1, 8));
            random_items += count;
         end else begin
            side    = (size_value == 0) ? 1 : size_value;
            repeats = $urandom_range(1, 3);
            while (repeats > 0 && random_items < 170) begin
               send_random(side * side, $urandom_range(1, 14));
               random_items += side * side;
               repeats--;
            end
            if (side > 1 && random_items < 170 && $urandom_range(0, 4) == 0) begin
               count = $urandom_range(1, side * side - 1);
               send_random(count, $urandom_range(1, 14));
               random_items += count;
            end
         end
         wait_idle();
      end

      // Closing phase at full rate on both sides.
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      write_size(ipd_pkg::SIZE_W'(5));
      send_random(50, 3);
      wait_idle();

      if (predictor.mismatch_count == 0 && predictor.pending_decisions.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/ipd_pkg.sv
src/ipd_cell.sv
src/ipd_window.sv
src/ipd_ctrl.sv
src/isolated_pixel_detector.sv
src/ipd_checker.sv
verif/tb_isolated_pixel_detector.sv
